FILE: src/pid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants for the packet impairment delay table
// Action codes, table sizes and the random generator step.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int SLOTS       = 64;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam logic [10:0] MAX_PAYLOAD = 11'd1500;
  localparam logic [31:0] RNG_SEED    = 32'd12345;
  localparam logic [15:0] DUP_SPAN_DEF = 16'd5;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_QUEUED  = 2'd1,
    ACT_DROPPED = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_LATENCY = 2'd0,
    REG_JITTER  = 2'd1,
    REG_LOSS    = 2'd2,
    REG_DUP     = 2'd3
  } reg_idx_t;

  // Slot contents carried along the cell chain
  typedef struct packed {
    logic        valid;
    logic [31:0] due;
    logic [15:0] pref;
    logic [10:0] plen;
  } slot_t;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic        shift;   // rotate chain by one
    logic        clear;   // drop all entries
    logic        tick;    // release head if due
    logic        insert;  // fill head if free
    logic [31:0] now;
    slot_t       ins;
  } chain_ctl_t;

  // xorshift32 step
  function automatic logic [31:0] rng_next(input logic [31:0] x);
    logic [31:0] a, b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

FILE: src/pid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_cell: one slot of the delay table
// Holds one entry and passes it to the next cell when the chain rotates.
// ----------------------------------------------------------------------------
module pid_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pid_pkg::chain_ctl_t ctl,
  input  pid_pkg::slot_t     prev,
  output pid_pkg::slot_t     cur
);

  pid_pkg::slot_t slot_r;

  assign cur = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      slot_r.valid <= 1'b0;
    end else if (ctl.shift) begin
      slot_r <= prev;
    end
  end

endmodule

FILE: src/pid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_div: restoring divider, 32-bit dividend by 16-bit divisor, remainder only
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pid_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] rem
);

  logic [31:0] num_r;
  logic [16:0] rem_r;
  logic [15:0] dsr_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [16:0] trial;
  logic [17:0] diff;

  assign trial = {rem_r[15:0], num_r[31]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_r};
  assign rem   = rem_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= diff[17] ? trial : diff[16:0];
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/packet_impairment_delay_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_impairment_delay_table_core: network impairment engine with delay table
// Drops, delays and duplicates packets; a ring of slot cells holds delayed ones.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  : one word per packet (kind 0) or millisecond tick (kind 1).
//  out_* : result words; out_last marks the final result of an input word.
//  cfg_* : register writes (index 0..3), only while idle; any write empties
//          the table.
//  One word is worked at a time. A tick rotates the 64-cell ring once,
//  releasing due entries in slot order. A packet rotates the ring to find
//  the lowest free slot, and each modulo for jitter or duplicate spacing
//  is worked in the serial divider; inactive packets skip both.
//  Results sit in an output register; while out_stall is high the engine
//  waits holding that word.
//  Reset: generator 12345, clock 0, table empty.
// ----------------------------------------------------------------------------
module packet_impairment_delay_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_packet_ref,
  input  logic [10:0] in_packet_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [15:0] out_out_ref,
  output logic [10:0] out_out_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOSS, S_JIT, S_JIT_W, S_DUP, S_ENQ, S_ENQ_RUN, S_EXTRA,
    S_EXTRA_W, S_TICK, S_TICK_END, S_EMIT
  } state_t;

  state_t       state_r;
  logic [15:0]  lat_r, loss_r, dupth_r;
  logic [14:0]  jit_r;
  logic [31:0]  rng_r, now_r;
  logic         kind_r;
  logic [15:0]  ref_r;
  logic [10:0]  len_r;
  logic [31:0]  delay_r;
  logic         dup_r, second_r, placed_r;
  logic [pid_pkg::SLOT_W:0] cnt_r;
  logic         any_rel_r;
  logic [15:0]  rel_ref_r;
  logic [10:0]  rel_len_r;
  logic         div_start;
  logic [31:0]  div_num;
  logic [15:0]  div_den;
  logic         div_done;
  logic [15:0]  div_rem;
  logic [31:0]  rng_n;
  logic         active;
  logic [15:0]  dup_m;
  logic [10:0]  stored_len;
  state_t       after_emit_r;

  pid_pkg::chain_ctl_t ctl;
  pid_pkg::slot_t      link [pid_pkg::SLOTS+1];
  pid_pkg::slot_t      head;
  pid_pkg::slot_t      feed;
  logic                head_due;

  assign rng_n      = pid_pkg::rng_next(rng_r);
  assign active     = (lat_r != '0) || (loss_r != '0) || (dupth_r != '0);
  assign dup_m      = (jit_r != '0) ? {1'b0, jit_r} : pid_pkg::DUP_SPAN_DEF;
  assign stored_len = (len_r > pid_pkg::MAX_PAYLOAD) ? pid_pkg::MAX_PAYLOAD : len_r;
  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE) && !out_valid;

  // ring: the head is the last cell's output; it feeds back through the head logic into cell 0
  assign head     = link[pid_pkg::SLOTS];
  assign head_due = head.valid && !(now_r - head.due >= 32'h8000_0000);

  always_comb begin
    feed = head;
    if (state_r == S_TICK && active && head_due) feed.valid = 1'b0;
    if (state_r == S_ENQ_RUN && !placed_r && !head.valid) begin
      feed.valid = 1'b1;
      feed.due   = delay_r;
      feed.pref  = ref_r;
      feed.plen  = stored_len;
    end
  end
  assign link[0] = feed;

  always_comb begin
    ctl       = '0;
    ctl.now   = now_r;
    ctl.clear = cfg_valid && cfg_ready;
    ctl.tick  = (state_r == S_TICK);
    ctl.insert = (state_r == S_ENQ_RUN);
    ctl.ins   = feed;
    ctl.shift = ((state_r == S_TICK) || (state_r == S_ENQ_RUN)) && !(out_valid && out_stall);
  end

  genvar g;
  generate
    for (g = 0; g < pid_pkg::SLOTS; g++) begin : g_cell
      pid_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .prev(link[g]), .cur(link[g+1]));
    end
  endgenerate

  // divider starts in the cycle after the draw, so it takes the drawn word
  assign div_num = rng_r;
  assign div_den = (state_r == S_JIT_W) ? ({jit_r, 1'b0} + 16'd1) : dup_m;

  pid_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
                 .divisor(div_den), .done(div_done), .rem(div_rem));

  logic [31:0] jd;
  assign jd = {16'd0, lat_r} + {16'd0, div_rem} - {17'd0, jit_r};

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      rng_r     <= pid_pkg::RNG_SEED;
      now_r     <= '0;
      lat_r     <= '0;
      jit_r     <= '0;
      loss_r    <= '0;
      dupth_r   <= '0;
      div_start <= 1'b0;
      any_rel_r <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (pid_pkg::reg_idx_t'(cfg_index))
          pid_pkg::REG_LATENCY: lat_r   <= cfg_data;
          pid_pkg::REG_JITTER:  jit_r   <= cfg_data[14:0];
          pid_pkg::REG_LOSS:    loss_r  <= cfg_data;
          pid_pkg::REG_DUP:     dupth_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ref_r     <= in_packet_ref;
            len_r     <= in_packet_length;
            kind_r    <= in_kind;
            dup_r     <= 1'b0;
            second_r  <= 1'b0;
            any_rel_r <= 1'b0;
            cnt_r     <= '0;
            if (in_kind) begin
              now_r <= now_r + 32'd1;
              state_r <= S_TICK;
            end else if (!active) begin
              out_action     <= pid_pkg::ACT_SEND;
              out_out_ref    <= in_packet_ref;
              out_out_length <= in_packet_length;
              out_last       <= 1'b1;
              out_valid      <= 1'b1;
              state_r        <= S_EMIT;
              after_emit_r   <= S_IDLE;
            end else begin
              state_r <= S_LOSS;
            end
          end
        end
        S_LOSS: begin
          if (loss_r != '0) begin
            rng_r <= rng_n;
            if (rng_n[15:0] < loss_r) begin
              out_action     <= pid_pkg::ACT_DROPPED;
              out_out_ref    <= ref_r;
              out_out_length <= len_r;
              out_last       <= 1'b1;
              out_valid      <= 1'b1;
              state_r        <= S_EMIT;
              after_emit_r   <= S_IDLE;
            end else state_r <= S_JIT;
          end else state_r <= S_JIT;
          delay_r <= {16'd0, lat_r};
        end
        S_JIT: begin
          if (jit_r != '0) begin
            div_start <= 1'b1;
            rng_r     <= rng_n;
            state_r   <= S_JIT_W;
          end else state_r <= S_DUP;
        end
        S_JIT_W: begin
          if (div_done) begin
            delay_r <= jd[31] ? 32'd0 : jd;
            state_r <= S_DUP;
          end
        end
        S_DUP: begin
          if (dupth_r != '0) begin
            rng_r <= rng_n;
            dup_r <= (rng_n[15:0] < dupth_r);
          end
          state_r <= S_ENQ;
        end
        S_ENQ: begin
          // delay_r holds the total delay; zero means send now
          if (delay_r == '0) begin
            out_action     <= pid_pkg::ACT_SEND;
            out_out_ref    <= ref_r;
            out_out_length <= len_r;
            out_last       <= !dup_r || second_r;
            out_valid      <= 1'b1;
            state_r        <= S_EMIT;
            after_emit_r   <= (dup_r && !second_r) ? S_EXTRA : S_IDLE;
          end else begin
            delay_r  <= delay_r + now_r;
            placed_r <= 1'b0;
            cnt_r    <= '0;
            state_r  <= S_ENQ_RUN;
          end
        end
        S_ENQ_RUN: begin
          if (ctl.shift) begin
            if (!placed_r && !head.valid) placed_r <= 1'b1;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == (pid_pkg::SLOTS - 1)) begin
              out_action     <= (placed_r || !head.valid) ? pid_pkg::ACT_QUEUED
                                                          : pid_pkg::ACT_SEND;
              out_out_ref    <= ref_r;
              out_out_length <= (placed_r || !head.valid) ? stored_len : len_r;
              out_last       <= !dup_r || second_r;
              out_valid      <= 1'b1;
              delay_r        <= delay_r - now_r;
              state_r        <= S_EMIT;
              after_emit_r   <= (dup_r && !second_r) ? S_EXTRA : S_IDLE;
            end
          end
        end
        S_EXTRA: begin
          second_r <= 1'b1;
          if (dup_m > 16'd1) begin
            div_start <= 1'b1;
            rng_r     <= rng_n;
            state_r   <= S_EXTRA_W;
          end else begin
            delay_r <= delay_r + 32'd1;
            state_r <= S_ENQ;
          end
        end
        S_EXTRA_W: begin
          if (div_done) begin
            delay_r <= delay_r + 32'd1 + {16'd0, div_rem};
            state_r <= S_ENQ;
          end
        end
        // A release word is held until the next one is found, so out_last
        // can be set on the final one.
        S_TICK: begin
          if (ctl.shift) begin
            cnt_r <= cnt_r + 1'b1;
            if (active && head_due) begin
              if (any_rel_r) begin
                out_action     <= pid_pkg::ACT_RELEASE;
                out_out_ref    <= rel_ref_r;
                out_out_length <= rel_len_r;
                out_last       <= 1'b0;
                out_valid      <= 1'b1;
              end
              any_rel_r <= 1'b1;
              rel_ref_r <= head.pref;
              rel_len_r <= head.plen;
            end
            if (cnt_r == (pid_pkg::SLOTS - 1)) state_r <= S_TICK_END;
          end
        end
        S_TICK_END: begin
          // flush the held release as the last word of the tick
          if (!(out_valid && out_stall)) begin
            if (any_rel_r) begin
              out_action     <= pid_pkg::ACT_RELEASE;
              out_out_ref    <= rel_ref_r;
              out_out_length <= rel_len_r;
              out_last       <= 1'b1;
              out_valid      <= 1'b1;
            end
            any_rel_r    <= 1'b0;
            state_r      <= S_EMIT;
            after_emit_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!(out_valid && out_stall)) state_r <= after_emit_r;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fields kept for visibility only
  logic unused_ok;
  assign unused_ok = kind_r ^ ctl.tick ^ ctl.insert ^ ctl.ins.valid;

  // checks
  property p_no_in_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> in_stall;
  endproperty
  a_no_in_busy: assert property (p_no_in_busy) else $error("input taken while busy");

  property p_cfg_idle;
    @(posedge clk) disable iff (!rst_n) (cfg_valid && cfg_ready) |-> (state_r == S_IDLE);
  endproperty
  a_cfg_idle: assert property (p_cfg_idle) else $error("config write while busy");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_stall) |=> (out_valid && $stable(out_out_ref));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

endmodule
